[hw/rtl/atbu_pkg.sv]
// Types and constants shared by the branch unit stages.
// No dependencies.
`timescale 1ns / 1ps

package atbu_pkg;

  typedef enum logic [3:0] {
    CMD_BX        = 4'd0,
    CMD_BLX_REG   = 4'd1,
    CMD_B         = 4'd2,
    CMD_BL        = 4'd3,
    CMD_BLX_IMM   = 4'd4,
    CMD_SWI       = 4'd5,
    CMD_BX_T      = 4'd6,
    CMD_BLXREG_T  = 4'd7,
    CMD_BCOND_T   = 4'd8,
    CMD_B_T       = 4'd9,
    CMD_BLSETUP_T = 4'd10,
    CMD_BLOFF_T   = 4'd11,
    CMD_BLXOFF_T  = 4'd12,
    CMD_SWI_T     = 4'd13
  } cmd_e;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_AL = 4'd14,
    COND_NV = 4'd15
  } cond_e;

  typedef enum logic [1:0] {
    PCS_KEEP,
    PCS_OPERAND,
    PCS_SUM
  } pc_src_e;

  typedef enum logic [2:0] {
    POFF_ZERO,
    POFF_ARM,
    POFF_ARMX,
    POFF_COND,
    POFF_B11,
    POFF_LONG,
    POFF_M4
  } pc_off_e;

  typedef enum logic [1:0] {
    LOFF_M4,
    LOFF_M1,
    LOFF_HI
  } lr_off_e;

  localparam logic [1:0]  CYC_NONE   = 2'd0;
  localparam logic [1:0]  CYC_SHORT  = 2'd1;
  localparam logic [1:0]  CYC_BRANCH = 2'd3;
  localparam logic [31:0] OFF_MINUS4 = 32'hFFFF_FFFC;
  localparam logic [31:0] OFF_MINUS1 = 32'hFFFF_FFFF;

  typedef struct packed {
    pc_src_e     pc_src;
    logic        pc_from_lr;
    pc_off_e     pc_off;
    lr_off_e     lr_off;
    logic        pc_written;
    logic        lr_written;
    logic        thumb;
    logic        flush;
    logic        exc;
    logic [1:0]  cycles;
  } ctrl_t;

  typedef struct packed {
    ctrl_t       ctrl;
    logic [24:0] imm;
    logic [31:0] operand;
    logic [31:0] pc;
    logic [31:0] lr;
  } dec_t;

  typedef struct packed {
    ctrl_t       ctrl;
    logic [31:0] pc_sum;
    logic [31:0] lr_sum;
    logic [31:0] operand;
    logic [31:0] pc;
    logic [31:0] lr;
  } sum_t;

endpackage

[hw/rtl/atbu_cmd_if.sv]
// Instruction channel of the branch unit: valid/ready plus the command beat.
// No dependencies.
`timescale 1ns / 1ps

interface atbu_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [31:0] opcode;
  logic [31:0] operand_value;
  logic [31:0] pc_value;
  logic [31:0] lr_value;
  logic [3:0]  nzcv;
  logic        thumb_in;

  modport source (
    output valid, command, opcode, operand_value, pc_value, lr_value, nzcv, thumb_in,
    input  ready
  );
  modport sink (
    input  valid, command, opcode, operand_value, pc_value, lr_value, nzcv, thumb_in,
    output ready
  );
endinterface

[hw/rtl/atbu_res_if.sv]
// Result channel of the branch unit: valid/ready plus the result beat.
// No dependencies.
`timescale 1ns / 1ps

interface atbu_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_pc;
  logic        pc_written;
  logic [31:0] new_lr;
  logic        lr_written;
  logic        thumb_out;
  logic        flush;
  logic        exception_request;
  logic [1:0]  cycles;

  modport source (
    output valid, new_pc, pc_written, new_lr, lr_written, thumb_out, flush,
           exception_request, cycles,
    input  ready
  );
  modport sink (
    input  valid, new_pc, pc_written, new_lr, lr_written, thumb_out, flush,
           exception_request, cycles,
    output ready
  );
endinterface

[hw/rtl/atbu_decode.sv]
// Stage 1: command decode and condition check, registered.
// Depends on atbu_pkg and atbu_cmd_if.
`timescale 1ns / 1ps

module atbu_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  atbu_cmd_if.sink        in_i,
  output logic            valid_o,
  input  logic            ready_i,
  output atbu_pkg::dec_t  dec_o
);

  logic            valid_q;
  atbu_pkg::dec_t  dec_d, dec_q;
  atbu_pkg::ctrl_t ctrl;
  logic            n, z, c, v, taken;

  assign in_i.ready = !valid_q || ready_i;

  always_comb begin
    n = in_i.nzcv[3];
    z = in_i.nzcv[2];
    c = in_i.nzcv[1];
    v = in_i.nzcv[0];
    case (atbu_pkg::cond_e'(in_i.opcode[11:8]))
      atbu_pkg::COND_EQ: taken = z;
      atbu_pkg::COND_NE: taken = !z;
      atbu_pkg::COND_CS: taken = c;
      atbu_pkg::COND_CC: taken = !c;
      atbu_pkg::COND_MI: taken = n;
      atbu_pkg::COND_PL: taken = !n;
      atbu_pkg::COND_VS: taken = v;
      atbu_pkg::COND_VC: taken = !v;
      atbu_pkg::COND_HI: taken = c && !z;
      atbu_pkg::COND_LS: taken = !c || z;
      atbu_pkg::COND_GE: taken = (n == v);
      atbu_pkg::COND_LT: taken = (n != v);
      atbu_pkg::COND_GT: taken = !z && (n == v);
      atbu_pkg::COND_LE: taken = z || (n != v);
      atbu_pkg::COND_AL: taken = 1'b1;
      default:           taken = 1'b0;
    endcase
  end

  always_comb begin
    ctrl            = '0;
    ctrl.pc_src     = atbu_pkg::PCS_KEEP;
    ctrl.pc_off     = atbu_pkg::POFF_ZERO;
    ctrl.lr_off     = atbu_pkg::LOFF_M4;
    ctrl.thumb      = in_i.thumb_in;
    ctrl.cycles     = atbu_pkg::CYC_NONE;
    case (atbu_pkg::cmd_e'(in_i.command))
      atbu_pkg::CMD_BX, atbu_pkg::CMD_BX_T: begin
        ctrl.pc_src     = atbu_pkg::PCS_OPERAND;
        ctrl.thumb      = in_i.operand_value[0];
        ctrl.pc_written = 1'b1;
        ctrl.flush      = 1'b1;
        ctrl.cycles     = atbu_pkg::CYC_BRANCH;
      end
      atbu_pkg::CMD_BLX_REG, atbu_pkg::CMD_BLXREG_T: begin
        ctrl.pc_src     = atbu_pkg::PCS_OPERAND;
        ctrl.lr_off     = (in_i.command == atbu_pkg::CMD_BLX_REG) ?
                          atbu_pkg::LOFF_M4 : atbu_pkg::LOFF_M1;
        ctrl.lr_written = 1'b1;
        ctrl.thumb      = in_i.operand_value[0];
        ctrl.pc_written = 1'b1;
        ctrl.flush      = 1'b1;
        ctrl.cycles     = atbu_pkg::CYC_BRANCH;
      end
      atbu_pkg::CMD_B, atbu_pkg::CMD_BL, atbu_pkg::CMD_BLX_IMM: begin
        ctrl.pc_src     = atbu_pkg::PCS_SUM;
        ctrl.pc_off     = (in_i.command == atbu_pkg::CMD_BLX_IMM) ?
                          atbu_pkg::POFF_ARMX : atbu_pkg::POFF_ARM;
        ctrl.lr_written = (in_i.command != atbu_pkg::CMD_B);
        if (in_i.command == atbu_pkg::CMD_BLX_IMM) begin
          ctrl.thumb = 1'b1;
        end
        ctrl.pc_written = 1'b1;
        ctrl.flush      = 1'b1;
        ctrl.cycles     = atbu_pkg::CYC_BRANCH;
      end
      atbu_pkg::CMD_SWI, atbu_pkg::CMD_SWI_T: begin
        ctrl.pc_src     = atbu_pkg::PCS_SUM;
        ctrl.pc_off     = atbu_pkg::POFF_M4;
        ctrl.pc_written = 1'b1;
        ctrl.exc        = 1'b1;
      end
      atbu_pkg::CMD_BCOND_T: begin
        if (taken) begin
          ctrl.pc_src     = atbu_pkg::PCS_SUM;
          ctrl.pc_off     = atbu_pkg::POFF_COND;
          ctrl.pc_written = 1'b1;
          ctrl.flush      = 1'b1;
          ctrl.cycles     = atbu_pkg::CYC_BRANCH;
        end else begin
          ctrl.cycles = atbu_pkg::CYC_SHORT;
        end
      end
      atbu_pkg::CMD_B_T: begin
        ctrl.pc_src     = atbu_pkg::PCS_SUM;
        ctrl.pc_off     = atbu_pkg::POFF_B11;
        ctrl.pc_written = 1'b1;
        ctrl.flush      = 1'b1;
        ctrl.cycles     = atbu_pkg::CYC_BRANCH;
      end
      atbu_pkg::CMD_BLSETUP_T: begin
        ctrl.lr_off     = atbu_pkg::LOFF_HI;
        ctrl.lr_written = 1'b1;
        ctrl.cycles     = atbu_pkg::CYC_SHORT;
      end
      atbu_pkg::CMD_BLOFF_T, atbu_pkg::CMD_BLXOFF_T: begin
        ctrl.pc_src     = atbu_pkg::PCS_SUM;
        ctrl.pc_from_lr = 1'b1;
        ctrl.pc_off     = atbu_pkg::POFF_LONG;
        ctrl.pc_written = 1'b1;
        ctrl.lr_off     = atbu_pkg::LOFF_M1;
        ctrl.lr_written = 1'b1;
        if (in_i.command == atbu_pkg::CMD_BLXOFF_T) begin
          ctrl.thumb = 1'b0;
        end
        ctrl.flush      = 1'b1;
        ctrl.cycles     = atbu_pkg::CYC_BRANCH;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    dec_d.ctrl    = ctrl;
    dec_d.imm     = in_i.opcode[24:0];
    dec_d.operand = in_i.operand_value;
    dec_d.pc      = in_i.pc_value;
    dec_d.lr      = in_i.lr_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

[hw/rtl/atbu_target.sv]
// Stage 2: offset build and target / link adders, registered.
// Depends on atbu_pkg.
`timescale 1ns / 1ps

module atbu_target (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  atbu_pkg::dec_t  dec_i,
  output logic            valid_o,
  input  logic            ready_i,
  output atbu_pkg::sum_t  sum_o
);

  logic           valid_q;
  atbu_pkg::sum_t sum_d, sum_q;
  logic [31:0]    pc_off, lr_off, pc_base;
  logic [24:0]    imm;

  assign ready_o = !valid_q || ready_i;
  assign imm     = dec_i.imm;

  always_comb begin
    case (dec_i.ctrl.pc_off)
      atbu_pkg::POFF_ARM:  pc_off = {{6{imm[23]}}, imm[23:0], 2'b00};
      atbu_pkg::POFF_ARMX: pc_off = {{6{imm[23]}}, imm[23:0], imm[24], 1'b0};
      atbu_pkg::POFF_COND: pc_off = {{23{imm[7]}}, imm[7:0], 1'b0};
      atbu_pkg::POFF_B11:  pc_off = {{20{imm[10]}}, imm[10:0], 1'b0};
      atbu_pkg::POFF_LONG: pc_off = {20'd0, imm[10:0], 1'b0};
      atbu_pkg::POFF_M4:   pc_off = atbu_pkg::OFF_MINUS4;
      default:             pc_off = '0;
    endcase
    case (dec_i.ctrl.lr_off)
      atbu_pkg::LOFF_M1: lr_off = atbu_pkg::OFF_MINUS1;
      atbu_pkg::LOFF_HI: lr_off = {{9{imm[10]}}, imm[10:0], 12'd0};
      default:           lr_off = atbu_pkg::OFF_MINUS4;
    endcase
    pc_base = dec_i.ctrl.pc_from_lr ? dec_i.lr : dec_i.pc;
  end

  always_comb begin
    sum_d.ctrl    = dec_i.ctrl;
    sum_d.pc_sum  = pc_base + pc_off;
    sum_d.lr_sum  = dec_i.pc + lr_off;
    sum_d.operand = dec_i.operand;
    sum_d.pc      = dec_i.pc;
    sum_d.lr      = dec_i.lr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;

endmodule

[hw/rtl/atbu_result.sv]
// Stage 3: result select into the output register that drives the result beat.
// Depends on atbu_pkg and atbu_res_if.
`timescale 1ns / 1ps

module atbu_result (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  atbu_pkg::sum_t  sum_i,
  atbu_res_if.source      out_o
);

  logic        valid_q;
  logic [31:0] new_pc_d, new_pc_q;
  logic [31:0] new_lr_d, new_lr_q;
  logic        pc_written_q, lr_written_q, thumb_q, flush_q, exc_q;
  logic [1:0]  cycles_q;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    case (sum_i.ctrl.pc_src)
      atbu_pkg::PCS_OPERAND: new_pc_d = sum_i.operand;
      atbu_pkg::PCS_SUM:     new_pc_d = sum_i.pc_sum;
      default:               new_pc_d = sum_i.pc;
    endcase
    new_lr_d = sum_i.ctrl.lr_written ? sum_i.lr_sum : sum_i.lr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      new_pc_q     <= new_pc_d;
      new_lr_q     <= new_lr_d;
      pc_written_q <= sum_i.ctrl.pc_written;
      lr_written_q <= sum_i.ctrl.lr_written;
      thumb_q      <= sum_i.ctrl.thumb;
      flush_q      <= sum_i.ctrl.flush;
      exc_q        <= sum_i.ctrl.exc;
      cycles_q     <= sum_i.ctrl.cycles;
    end
  end

  assign out_o.valid             = valid_q;
  assign out_o.new_pc            = new_pc_q;
  assign out_o.pc_written        = pc_written_q;
  assign out_o.new_lr            = new_lr_q;
  assign out_o.lr_written        = lr_written_q;
  assign out_o.thumb_out         = thumb_q;
  assign out_o.flush             = flush_q;
  assign out_o.exception_request = exc_q;
  assign out_o.cycles            = cycles_q;

endmodule

[hw/rtl/arm_thumb_branch_unit.sv]
// ARM/THUMB branch execute unit: decode, add, result select in three stages.
// An accepted instruction beat passes the decode, target and result registers in turn to its result beat.
// Throughput 1 beat per cycle while the result sink is ready; each stage register advances when the next is free.
// Reset clears the stage valid bits only; the stage data registers are not reset.
// Depends on atbu_pkg, atbu_cmd_if, atbu_res_if and the three stage modules.
`timescale 1ns / 1ps

module arm_thumb_branch_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  atbu_cmd_if.sink   in_i,
  atbu_res_if.source out_o
);

  logic           dec_valid, dec_ready;
  logic           sum_valid, sum_ready;
  atbu_pkg::dec_t dec;
  atbu_pkg::sum_t sum;

  atbu_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .dec_o   (dec)
  );

  atbu_target u_target (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .sum_o   (sum)
  );

  atbu_result u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .sum_i   (sum),
    .out_o   (out_o)
  );

endmodule
